### design/lalu_pkg.sv
// ----------------------------------------------------------------------------
// lalu_pkg: shared types and constants for the lite ALU with feedback
// Opcode encoding, configuration register indexes and port widths.
// ----------------------------------------------------------------------------
package lalu_pkg;

    // Operation select, dense encoding
    typedef enum logic [2:0] {
        OP_OR  = 3'd0,
        OP_AND = 3'd1,
        OP_SGT = 3'd2,
        OP_MUX = 3'd3,
        OP_SUB = 3'd4,
        OP_ADD = 3'd5,
        OP_MAX = 3'd6,
        OP_MIN = 3'd7
    } alu_op_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPCODE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_EN = 1'd1;

    // Widest configuration register
    localparam int CFG_DATA_W = 3;

    // Fixed field widths on the streams
    localparam int OPND_W   = 32;
    localparam int IN_DATA_W  = 2 * OPND_W;
    localparam int OUT_DATA_W = OPND_W;

endpackage

### design/lite_alu_with_feedback.sv
// ----------------------------------------------------------------------------
// lite_alu_with_feedback: small signed ALU with output feedback and delay line
// Two-stage stream pipeline: input register, then one ALU pass into the
// result register, with a delay line of LATENCY-1 entries on the computed values.
// ----------------------------------------------------------------------------

// Throughput is one item per clock while the output side is ready: each item
// passes the input register and then the ALU pass that loads the result
// register, and a new item may enter as the last one moves on.
// The rate is set by the registered feedback path from
// the ALU output back into last_value_reg, which the next item reads as its
// first operand when the feedback enable is set. Each item yields exactly one
// result: the value computed LATENCY-1 items earlier (LATENCY 1 gives the new
// value itself); run_start zeroes the delay line before the item is inserted,
// but last_value_reg survives it. Arithmetic wraps at WIDTH bits; operands are
// sign-extended or truncated to WIDTH and the result is the low 32 bits of
// the WIDTH-bit value (zero-filled above WIDTH). Program the opcode and the
// feedback enable through cfg_we/cfg_index/cfg_data only while the block is
// idle.
module lite_alu_with_feedback #(
    parameter int WIDTH   = 32,
    parameter int LATENCY = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write port
    input  logic                                 cfg_we,
    input  logic [lalu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lalu_pkg::CFG_DATA_W-1:0]      cfg_data,

    // input item stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lalu_pkg::IN_DATA_W-1:0]       s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic                                 s_tuser,   // [0] run_start

    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lalu_pkg::OUT_DATA_W-1:0]      m_tdata    // [31:0] result
);

    localparam logic [WIDTH-1:0] SIGN_BIT = {1'b1, {(WIDTH-1){1'b0}}};

    // ---------------- configuration ----------------
    lalu_pkg::alu_op_t opcode_reg;
    logic              loop_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg  <= lalu_pkg::OP_OR;
            loop_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lalu_pkg::CFG_OPCODE:  opcode_reg  <= lalu_pkg::alu_op_t'(cfg_data[2:0]);
                lalu_pkg::CFG_LOOP_EN: loop_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // advance: result register is free or being drained this cycle
    logic s1_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic s1_load;
    logic fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign s1_load  = s_tvalid && s_tready;
    assign fire     = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // ---------------- input register ----------------
    logic signed [lalu_pkg::OPND_W-1:0] s1_a_reg;
    logic signed [lalu_pkg::OPND_W-1:0] s1_b_reg;
    logic                               s1_start_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_a_reg     <= s_tdata[lalu_pkg::OPND_W-1:0];
            s1_b_reg     <= s_tdata[lalu_pkg::IN_DATA_W-1:lalu_pkg::OPND_W];
            s1_start_reg <= s_tuser;
        end
    end

    // ---------------- ALU pass ----------------
    logic signed [WIDTH-1:0] a_w;
    logic signed [WIDTH-1:0] b_w;
    logic signed [WIDTH-1:0] x_w;
    logic        [WIDTH-1:0] last_value_reg;
    logic        [WIDTH-1:0] new_value;
    logic                    a_neg;
    logic                    x_gt_b;

    // signed size cast sign-extends or truncates to WIDTH
    assign a_w    = WIDTH'(s1_a_reg);
    assign b_w    = WIDTH'(s1_b_reg);
    assign x_w    = loop_en_reg ? signed'(last_value_reg) : a_w;
    assign a_neg  = a_w[WIDTH-1];
    assign x_gt_b = x_w > b_w;

    always_comb
    begin
        new_value = last_value_reg;
        unique case (opcode_reg)
            lalu_pkg::OP_OR:  new_value = x_w | b_w;
            lalu_pkg::OP_AND: new_value = x_w & b_w;
            lalu_pkg::OP_SGT: new_value = x_gt_b ? SIGN_BIT : '0;
            lalu_pkg::OP_MUX:
                new_value = a_neg ? b_w : (loop_en_reg ? last_value_reg : '0);
            lalu_pkg::OP_SUB: new_value = a_neg ? b_w : (x_w - b_w);
            lalu_pkg::OP_ADD:
                new_value = (loop_en_reg && a_neg) ? b_w : (x_w + b_w);
            lalu_pkg::OP_MAX: new_value = a_neg ? last_value_reg : (x_gt_b ? x_w : b_w);
            lalu_pkg::OP_MIN: new_value = a_neg ? last_value_reg : (x_gt_b ? b_w : x_w);
            default:          new_value = last_value_reg;
        endcase
    end

    // feedback register: kept across run_start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_value_reg <= '0;
        else if (fire)
            last_value_reg <= new_value;
    end

    // ---------------- delay line ----------------
    // Only the LATENCY-1 younger entries are stored; the oldest one after the
    // shift is the result and goes straight into the output register.
    logic [WIDTH-1:0] oldest_value;

    generate
        if (LATENCY > 1)
        begin : g_delay
            logic [WIDTH-1:0] delay_reg [LATENCY-1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    for (int i = 0; i < LATENCY-1; i++)
                        delay_reg[i] <= '0;
                end
                else if (fire)
                begin
                    delay_reg[0] <= new_value;
                    for (int i = 1; i < LATENCY-1; i++)
                        delay_reg[i] <= s1_start_reg ? '0 : delay_reg[i-1];
                end
            end

            assign oldest_value = s1_start_reg ? '0 : delay_reg[LATENCY-2];
        end
        else
        begin : g_nodelay
            assign oldest_value = new_value;
        end
    endgenerate

    // ---------------- result register ----------------
    logic [lalu_pkg::OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= lalu_pkg::OUT_DATA_W'(oldest_value);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("s_tready low with empty result register");

    // feedback value changes only when an item passes the ALU
    a_feedback_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(last_value_reg))
        else $error("last_value_reg changed without an item");

    // a run start with a real delay line gives a zero result
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_start_reg && (LATENCY > 1)) |=> (m_tdata == '0))
        else $error("run_start did not clear the delay line");

    // a result appears only from an item held in the input register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result produced without an item");
`endif

endmodule
